// ----- src/button_click_page_controller_top_macros.svh -----
`ifndef BUTTON_CLICK_PAGE_CONTROLLER_TOP_MACROS_SVH
`define BUTTON_CLICK_PAGE_CONTROLLER_TOP_MACROS_SVH

// Same-cycle check: whenever the antecedent holds, the consequent must hold too.
`define BCPC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: the consequent must hold in the cycle after the antecedent.
`define BCPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bcpc_pkg.sv -----
package bcpc_pkg;

    // Configuration port geometry.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [1:0] REG_DOUBLE    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;
    localparam logic [1:0] REG_PAGES     = 2'd3;

    // Register reset values.
    localparam logic [15:0] DEBOUNCE_RST = 16'd50;
    localparam logic [15:0] DOUBLE_RST   = 16'd500;
    localparam logic [15:0] TIMEOUT_RST  = 16'd5000;
    localparam logic [3:0]  PAGES_RST    = 4'd3;

    // Stream beat widths.
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    // Configuration registers as one group.
    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] double_click_ms;
        logic [15:0] display_timeout_ms;
        logic [3:0]  page_count;
    } cfg_t;

    // Per-tick pulses produced by the step logic.
    typedef struct packed {
        logic page_print;
        logic page_reset;
    } flags_t;

endpackage

// ----- src/bcpc_step.sv -----
module bcpc_step
    import bcpc_pkg::*;
#(
    parameter int MAX_PAGES  = 8,
    parameter int TIMER_BITS = 16
) (
    input  logic                          press,
    input  cfg_t                          cfg,
    input  logic [TIMER_BITS-1:0]         since_press,
    input  logic                          click_pending,
    input  logic                          double_pending,
    input  logic [$clog2(MAX_PAGES)-1:0]  page_index,
    input  logic                          display_on,
    output logic [TIMER_BITS-1:0]         since_press_next,
    output logic                          click_pending_next,
    output logic                          double_pending_next,
    output logic [$clog2(MAX_PAGES)-1:0]  page_index_next,
    output logic                          display_on_next,
    output flags_t                        flags
);

    localparam int PW   = $clog2(MAX_PAGES);
    localparam int VW   = $clog2(MAX_PAGES + 1);
    localparam int EW   = (VW > 4) ? VW : 4;
    localparam int DW   = 2 * EW;
    localparam int CW   = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic [TIMER_BITS-1:0] sp_inc;
    logic [CW-1:0]         sp_inc_w;
    logic [CW-1:0]         sp_post_w;
    logic [CW-1:0]         deb_w;
    logic [CW-1:0]         dbl_w;
    logic [CW-1:0]         tmo_w;
    logic                  press_taken;
    logic                  in_window;
    logic                  click_mid;
    logic                  double_mid;
    logic                  display_mid;
    logic [TIMER_BITS-1:0] sp_post;
    logic [EW-1:0]         eff_pages;
    logic [EW-1:0]         pc_w;
    logic [DW-1:0]         rem;
    logic [DW-1:0]         sub;
    logic [PW-1:0]         page_adv;

    // The elapsed counter saturates at all ones.
    assign sp_inc   = (&since_press) ? since_press : since_press + 1'b1;
    assign sp_inc_w = CW'(sp_inc);
    assign deb_w    = CW'(cfg.debounce_ms);
    assign dbl_w    = CW'(cfg.double_click_ms);
    assign tmo_w    = CW'(cfg.display_timeout_ms);

    // Press judging: debounced press either opens a click or marks a double click.
    assign press_taken = press && (sp_inc_w >= deb_w);
    assign in_window   = click_pending && (sp_inc_w < dbl_w);
    assign double_mid  = (press_taken && in_window) ? 1'b1 : double_pending;
    assign click_mid   = (press_taken && !in_window) ? 1'b1 : click_pending;
    assign sp_post     = press_taken ? '0 : sp_inc;
    assign sp_post_w   = CW'(sp_post);

    // Effective page count, clamped to one at the bottom and MAX_PAGES at the top.
    assign pc_w = EW'(cfg.page_count);
    always_comb begin
        if (pc_w == '0) begin
            eff_pages = EW'(1);
        end else if (pc_w > EW'(MAX_PAGES)) begin
            eff_pages = EW'(MAX_PAGES);
        end else begin
            eff_pages = pc_w;
        end
    end

    // Next page index: (index + 1) mod count by restoring long division,
    // one narrow compare and subtract per quotient bit.
    always_comb begin
        rem = DW'(page_index) + DW'(1);
        sub = '0;
        for (int k = EW - 1; k >= 0; k--) begin
            sub = DW'(eff_pages) << k;
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        page_adv = PW'(rem);
    end

    // Pending click handling, then the idle timeout.
    always_comb begin
        click_pending_next  = click_mid;
        double_pending_next = double_mid;
        page_index_next     = page_index;
        display_mid         = display_on;
        flags               = '0;
        if (click_mid) begin
            priority if (!display_on) begin
                display_mid        = 1'b1;
                click_pending_next = 1'b0;
            end else if (double_mid) begin
                flags.page_reset    = 1'b1;
                double_pending_next = 1'b0;
                click_pending_next  = 1'b0;
            end else if (sp_post_w > dbl_w) begin
                page_index_next    = page_adv;
                flags.page_print   = 1'b1;
                click_pending_next = 1'b0;
            end else begin
                // The window is still open, so the click stays pending.
                click_pending_next = click_mid;
            end
        end
        display_on_next = display_mid && !(sp_post_w > tmo_w);
    end

    assign since_press_next = sp_post;

endmodule

// ----- src/button_click_page_controller_top.sv -----
// Channel  | Ports                       | Beat contents (lowest bit first)
// ---------+-----------------------------+-----------------------------------------------
// input    | s_tvalid s_tready s_tdata   | button_press
// result   | m_tvalid m_tready m_tdata   | display_lit, current_page[2:0], page_print,
//          |                             | page_reset
// config   | psel penable pwrite paddr.. | debounce, double-click, timeout, page count
//
// Each tick beat is latched in an input register, evaluated by the compare and
// counter logic, and lands in a result register. One beat is accepted every
// clock while the result register drains; the only stall comes from m_tready
// held low with both registers full.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// counter and click flags, selects page zero and switches the display on.
module button_click_page_controller_top
    import bcpc_pkg::*;
#(
    parameter int MAX_PAGES  = 8,
    parameter int TIMER_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: [0] button_press, [7:1] zero
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // m_tdata: [0] display_lit, [3:1] current_page, [4] page_print, [5] page_reset,
    // [7:6] zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

`include "button_click_page_controller_top_macros.svh"

    localparam int PW = $clog2(MAX_PAGES);

    cfg_t                  cfg_reg;
    logic [TIMER_BITS-1:0] since_press_reg;
    logic                  click_pending_reg;
    logic                  double_pending_reg;
    logic [PW-1:0]         page_index_reg;
    logic                  display_on_reg;

    logic                  in_valid_reg;
    logic                  in_press_reg;
    logic                  out_valid_reg;
    logic                  out_display_reg;
    logic [2:0]            out_page_reg;
    flags_t                out_flags_reg;

    logic [TIMER_BITS-1:0] since_press_next;
    logic                  click_pending_next;
    logic                  double_pending_next;
    logic [PW-1:0]         page_index_next;
    logic                  display_on_next;
    flags_t                flags;

    logic                  advance;
    logic                  cfg_write;
    logic [1:0]            reg_sel;

    // Configuration port: writes land on the access phase, reads are combinational.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms        <= DEBOUNCE_RST;
            cfg_reg.double_click_ms    <= DOUBLE_RST;
            cfg_reg.display_timeout_ms <= TIMEOUT_RST;
            cfg_reg.page_count         <= PAGES_RST;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_DEBOUNCE: cfg_reg.debounce_ms        <= pwdata[15:0];
                REG_DOUBLE:   cfg_reg.double_click_ms    <= pwdata[15:0];
                REG_TIMEOUT:  cfg_reg.display_timeout_ms <= pwdata[15:0];
                REG_PAGES:    cfg_reg.page_count         <= pwdata[3:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_DEBOUNCE: prdata = DATA_W'(cfg_reg.debounce_ms);
            REG_DOUBLE:   prdata = DATA_W'(cfg_reg.double_click_ms);
            REG_TIMEOUT:  prdata = DATA_W'(cfg_reg.display_timeout_ms);
            REG_PAGES:    prdata = DATA_W'(cfg_reg.page_count);
        endcase
    end

    // Handshake: the input register moves on whenever the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_press_reg <= s_tdata[0];
        end
    end

    // One tick of the click state machine.
    bcpc_step #(
        .MAX_PAGES  (MAX_PAGES),
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .press               (in_press_reg),
        .cfg                 (cfg_reg),
        .since_press         (since_press_reg),
        .click_pending       (click_pending_reg),
        .double_pending      (double_pending_reg),
        .page_index          (page_index_reg),
        .display_on          (display_on_reg),
        .since_press_next    (since_press_next),
        .click_pending_next  (click_pending_next),
        .double_pending_next (double_pending_next),
        .page_index_next     (page_index_next),
        .display_on_next     (display_on_next),
        .flags               (flags)
    );

    // State registers update once per evaluated tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            since_press_reg    <= '0;
            click_pending_reg  <= 1'b0;
            double_pending_reg <= 1'b0;
            page_index_reg     <= '0;
            display_on_reg     <= 1'b1;
        end else if (advance) begin
            since_press_reg    <= since_press_next;
            click_pending_reg  <= click_pending_next;
            double_pending_reg <= double_pending_next;
            page_index_reg     <= page_index_next;
            display_on_reg     <= display_on_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_display_reg <= display_on_next;
            out_page_reg    <= 3'(page_index_next);
            out_flags_reg   <= flags;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_flags_reg.page_reset, out_flags_reg.page_print,
                       out_page_reg, out_display_reg};

    // Checks on the pipeline and the click logic.
    `BCPC_ASSERT_NOW(a_one_pulse, aclk, aresetn, out_valid_reg,
        !(out_flags_reg.page_print && out_flags_reg.page_reset),
        "page_print and page_reset raised in the same beat")
    `BCPC_ASSERT_NOW(a_page_range, aclk, aresetn, 1'b1,
        page_index_reg < PW'(MAX_PAGES - 1) || page_index_reg == PW'(MAX_PAGES - 1),
        "page index beyond the page limit")
    `BCPC_ASSERT_NEXT(a_in_held, aclk, aresetn, in_valid_reg && !advance,
        in_valid_reg,
        "pending input beat dropped without evaluation")

endmodule
